/* src/idru_pkg.sv */
// ----------------------------------------------------------------------------
// idru_pkg
// Shared types and constants for the 64-bit divide / remainder unit.
// ----------------------------------------------------------------------------
package idru_pkg;

   localparam int DATA_WIDTH = 64;

   localparam logic [DATA_WIDTH-1:0] MOST_NEG_BITS  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] MINUS_ONE_BITS = {DATA_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      CMD_SDIV = 2'd0,
      CMD_SREM = 2'd1,
      CMD_UDIV = 2'd2,
      CMD_UREM = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [DATA_WIDTH-1:0]  dividend;
      logic [DATA_WIDTH-1:0]  divisor;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  result;
      logic [1:0]             status;
   } rsp_type;

   // control that rides along with one transaction through the cell chain
   typedef struct packed {
      logic        valid;
      logic        is_rem;
      logic        negate;
      status_type  status;
   } div_ctrl_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  rem;
      logic [DATA_WIDTH-1:0]  quo;
      logic [DATA_WIDTH-1:0]  dsr;
   } div_data_type;

endpackage

/* src/int64_divide_remainder_unit.sv */
// ----------------------------------------------------------------------------
// int64_divide_remainder_unit
// Pipelined 64-bit signed / unsigned divide and remainder.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the pipe is not stalled. Each request
// passes through one input stage for operand magnitudes and error checks,
// a chain of 64 division cells that each settle one quotient bit, and one
// output register that restores the sign. The whole pipe advances together;
// it stalls only while a result sits in the output register and rsp_ready is
// low. Signed forms truncate toward zero with the remainder taking the sign
// of the dividend; a zero divisor or most-negative divided by minus one gives
// result zero with an error status.
module int64_divide_remainder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  idru_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output idru_pkg::rsp_type rsp_data
);
   import idru_pkg::*;

   div_ctrl_type chain_ctrl [0:DATA_WIDTH];
   div_data_type chain_data [0:DATA_WIDTH];
   logic         advance;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   idru_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_data  (req_data),
      .dn_ctrl   (chain_ctrl[0]),
      .dn_data   (chain_data[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      idru_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctrl (chain_ctrl[i]),
         .up_data (chain_data[i]),
         .dn_ctrl (chain_ctrl[i+1]),
         .dn_data (chain_data[i+1])
      );
   end

   idru_post u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .up_ctrl   (chain_ctrl[DATA_WIDTH]),
      .up_data   (chain_data[DATA_WIDTH]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/idru_prep.sv */
// ----------------------------------------------------------------------------
// idru_prep
// Input stage: operand magnitudes, result sign and error detection.
// ----------------------------------------------------------------------------
module idru_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  req_valid,
   input  idru_pkg::req_type     req_data,
   output idru_pkg::div_ctrl_type dn_ctrl,
   output idru_pkg::div_data_type dn_data
);
   import idru_pkg::*;

   div_ctrl_type ctrl_ff, ctrl_in;
   div_data_type data_ff, data_in;
   logic         is_signed;
   logic         neg_a;
   logic         neg_b;

   assign is_signed = (req_data.cmd == CMD_SDIV) || (req_data.cmd == CMD_SREM);
   assign neg_a     = is_signed & req_data.dividend[DATA_WIDTH-1];
   assign neg_b     = is_signed & req_data.divisor[DATA_WIDTH-1];

   always_comb begin
      ctrl_in.valid  = req_valid;
      ctrl_in.is_rem = (req_data.cmd == CMD_SREM) || (req_data.cmd == CMD_UREM);
      // remainder follows the dividend, quotient the xor of both signs
      ctrl_in.negate = ctrl_in.is_rem ? neg_a : (neg_a ^ neg_b);
      if (req_data.divisor == '0) begin
         ctrl_in.status = STATUS_DIV_ZERO;
      end else if (is_signed && (req_data.dividend == MOST_NEG_BITS)
                   && (req_data.divisor == MINUS_ONE_BITS)) begin
         ctrl_in.status = STATUS_OVERFLOW;
      end else begin
         ctrl_in.status = STATUS_OK;
      end
      data_in.rem = '0;
      data_in.quo = neg_a ? (~req_data.dividend + 1'b1) : req_data.dividend;
      data_in.dsr = neg_b ? (~req_data.divisor + 1'b1) : req_data.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_data = data_ff;

endmodule

/* src/idru_cell.sv */
// ----------------------------------------------------------------------------
// idru_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module idru_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  idru_pkg::div_ctrl_type up_ctrl,
   input  idru_pkg::div_data_type up_data,
   output idru_pkg::div_ctrl_type dn_ctrl,
   output idru_pkg::div_data_type dn_data
);
   import idru_pkg::*;

   div_ctrl_type        ctrl_ff;
   div_data_type        data_ff, data_in;
   logic [DATA_WIDTH:0] trial;
   logic [DATA_WIDTH:0] diff;

   // shift the next dividend bit into the partial remainder
   assign trial = {up_data.rem, up_data.quo[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, up_data.dsr};

   always_comb begin
      data_in.dsr = up_data.dsr;
      if (!diff[DATA_WIDTH]) begin
         data_in.rem = diff[DATA_WIDTH-1:0];
         data_in.quo = {up_data.quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
         data_in.rem = trial[DATA_WIDTH-1:0];
         data_in.quo = {up_data.quo[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_data = data_ff;

endmodule

/* src/idru_post.sv */
// ----------------------------------------------------------------------------
// idru_post
// Output stage: picks quotient or remainder, restores sign, holds the result.
// ----------------------------------------------------------------------------
module idru_post (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  idru_pkg::div_ctrl_type up_ctrl,
   input  idru_pkg::div_data_type up_data,
   output logic                   rsp_valid,
   output idru_pkg::rsp_type      rsp_data
);
   import idru_pkg::*;

   logic                  valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [DATA_WIDTH-1:0] mag;

   assign mag = up_ctrl.is_rem ? up_data.rem : up_data.quo;

   always_comb begin
      rsp_in.status = up_ctrl.status;
      if (up_ctrl.status != STATUS_OK) begin
         rsp_in.result = '0;
      end else if (up_ctrl.negate) begin
         rsp_in.result = ~mag + 1'b1;
      end else begin
         rsp_in.result = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the 64-bit divide / remainder unit against a behavioral divider:
// corner operands for every command, random operand mixes, a drained pause
// and a stretch with no idling, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

   import idru_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_results [$];
   rsp_type expected_rsp;
   int      mismatch_count = 0;
   bit      idle_on = 1'b1;

   int64_divide_remainder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   // expected quotient or remainder, with c-style signed truncation
   function automatic rsp_type predict_division(input req_type item);
      rsp_type     r;
      logic        neg_a;
      logic        neg_b;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] quo;
      logic [63:0] rem;
      r.result = '0;
      r.status = STATUS_OK;
      neg_a    = item.dividend[DATA_WIDTH-1];
      neg_b    = item.divisor[DATA_WIDTH-1];
      if (item.divisor == '0) begin
         r.status = STATUS_DIV_ZERO;
      end else if (item.cmd == CMD_UDIV) begin
         r.result = item.dividend / item.divisor;
      end else if (item.cmd == CMD_UREM) begin
         r.result = item.dividend % item.divisor;
      end else if (item.dividend == MOST_NEG_BITS && item.divisor == MINUS_ONE_BITS) begin
         r.status = STATUS_OVERFLOW;
      end else begin
         mag_a = neg_a ? 64'd0 - item.dividend : item.dividend;
         mag_b = neg_b ? 64'd0 - item.divisor : item.divisor;
         quo   = mag_a / mag_b;
         rem   = mag_a % mag_b;
         if (item.cmd == CMD_SDIV) begin
            r.result = (neg_a != neg_b) ? 64'd0 - quo : quo;
         end else begin
            r.result = neg_a ? 64'd0 - rem : rem;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: v = 64'd0;
         1: v = 64'd1 << $urandom_range(0, 63);
         2: v = 64'($urandom_range(1, 20));
         3: v = 64'd0 - 64'($urandom_range(1, 20));
         4: v = MOST_NEG_BITS;
         5: v = MINUS_ONE_BITS;
         6: v = {32'd0, 32'($urandom)};
         7: v = {{32{1'b1}}, 32'($urandom)};
         default: v = {32'($urandom), 32'($urandom)};
      endcase
      return v;
   endfunction

   // holds valid until the transaction is taken, then records its result
   task automatic issue_division(input cmd_type cmd, input logic [63:0] a,
                                 input logic [63:0] b);
      req_type item;
      item.cmd      = cmd;
      item.dividend = a;
      item.divisor  = b;
      while (idle_on && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_results.push_back(predict_division(item));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_operands();
      logic [63:0] dividends [6];
      logic [63:0] divisors [6];
      dividends = '{MINUS_ONE_BITS, MOST_NEG_BITS, MOST_NEG_BITS,
                    64'd0 - 64'd7, 64'd7, 64'h7FFF_FFFF_FFFF_FFFF};
      divisors  = '{64'd0, MINUS_ONE_BITS, 64'd1,
                    64'd2, 64'd0 - 64'd2, 64'hFFFF_FFFF_FFFF_FFFE};
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 6; i++) begin
            issue_division(cmd_type'(c), dividends[i], divisors[i]);
         end
      end
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         issue_division(cmd_type'($urandom_range(0, 3)), random_operand(), random_operand());
      end
   endtask

   task automatic test_pause_until_empty();
      for (int n = 0; n < 2; n++) begin
         test_random_mix(60);
         wait_for_drain();
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random_mix(300);
      idle_on = 1'b1;
   endtask

   // result side: compare each transaction, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result, actual result %h status %0d", $time,
                     rsp_data.result, rsp_data.status);
         end else begin
            expected_rsp = pending_results.pop_front();
            if (rsp_data.result !== expected_rsp.result) begin
               mismatch_count++;
               $display("%0t: result expected %h actual %h", $time,
                        expected_rsp.result, rsp_data.result);
            end
            if (rsp_data.status !== expected_rsp.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d", $time,
                        expected_rsp.status, rsp_data.status);
            end
         end
      end
      rsp_ready <= !(idle_on && $urandom_range(0, 99) < 10);
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_corner_operands();
      test_random_mix(1000);
      test_pause_until_empty();
      test_back_to_back();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (pending_results.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
